FILE: design/battery_soc_estimator_defines.svh
// ----------------------------------------------------------------------------
// Battery state-of-charge estimator: assertion macros
// Shared assertion helpers for the estimator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BATTERY_SOC_ESTIMATOR_DEFINES_SVH
`define BATTERY_SOC_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BSE_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BSE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bse_pkg.sv
// ----------------------------------------------------------------------------
// Battery state-of-charge estimator package
// Field widths, the open-circuit-voltage table and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bse_pkg;

  localparam int ADC_BITS   = 12;
  localparam int GAIN_W     = 18;
  localparam int OFS_W      = 9;
  localparam int SOC_W      = 10;
  localparam int FILLED_W   = 7;
  localparam int GAIN_FRAC  = 16;
  localparam int PROD_W     = ADC_BITS + GAIN_W;
  localparam int MV_W       = PROD_W - GAIN_FRAC;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd168166;
  localparam logic [OFS_W-1:0]  OFS_RESET  = 9'd100;

  localparam int TABLE_POINTS = 21;
  localparam int SEG_IDX_W    = $clog2(TABLE_POINTS);
  localparam int SEG_W        = 9;
  localparam int STEP_W       = 6;
  localparam int INTERP_W     = SEG_W + STEP_W;

  localparam logic [MV_W-1:0] OCV_MV [TABLE_POINTS] = '{
    14'd3000, 14'd3280, 14'd3360, 14'd3420, 14'd3490, 14'd3550,
    14'd3610, 14'd3670, 14'd3710, 14'd3750, 14'd3790, 14'd3830,
    14'd3870, 14'd3910, 14'd3950, 14'd3980, 14'd4020, 14'd4080,
    14'd4110, 14'd4150, 14'd4200
  };

  localparam logic [SOC_W-1:0] SOC_PTS [TABLE_POINTS] = '{
    10'd0,   10'd50,  10'd100, 10'd150, 10'd200, 10'd250,
    10'd300, 10'd350, 10'd400, 10'd450, 10'd500, 10'd550,
    10'd600, 10'd650, 10'd700, 10'd750, 10'd800, 10'd850,
    10'd900, 10'd950, 10'd1000
  };

  typedef enum logic {
    REG_GAIN,
    REG_OFFSET
  } reg_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SEG,
    ST_ISTART,
    ST_IDIV,
    ST_COMMIT,
    ST_ASTART,
    ST_ADIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } ring_ctrl_t;

endpackage

FILE: design/bse_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial gain multiplier
// Forms adc_count * gain_q16 one converter bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bse_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bse_pkg::ADC_BITS-1:0] adc,
  input  logic [bse_pkg::GAIN_W-1:0]  gain,
  output logic                        done,
  output logic [bse_pkg::PROD_W-1:0]  product
);
  import bse_pkg::*;

  localparam int CNT_W = $clog2(ADC_BITS + 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [ADC_BITS-1:0] bits;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   acc_next;

  assign acc_next = {acc[PROD_W-2:0], 1'b0} +
                    (bits[ADC_BITS-1] ? PROD_W'(gain) : '0);
  assign product  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ADC_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      bits <= adc;
    end else if (busy) begin
      acc  <= acc_next;
      bits <= {bits[ADC_BITS-2:0], 1'b0};
    end
  end

endmodule

FILE: design/bse_div.sv
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Produces one quotient bit per cycle; shared by interpolation and averaging.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bse_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  import bse_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] qr;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem, qr[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};
  assign quot  = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr    <= num;
      den_r <= den;
      rem   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      qr  <= {qr[NUM_W-2:0], ge};
    end
  end

endmodule

FILE: design/bse_ring.sv
// ----------------------------------------------------------------------------
// Averaging window ring
// Holds the last WINDOW instant results with a running sum and fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bse_ring #(
  parameter int WINDOW = 100,
  parameter int SUM_W  = 17,
  parameter int FILL_W = 7,
  parameter int PTR_W  = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bse_pkg::ring_ctrl_t        ctrl,
  input  logic [bse_pkg::SOC_W-1:0]  soc,
  output logic [SUM_W-1:0]           sum,
  output logic [FILL_W-1:0]          fill
);
  import bse_pkg::*;

  logic [SOC_W-1:0] mem [WINDOW];
  logic [SOC_W-1:0] old_q;
  logic [PTR_W-1:0] wptr;
  logic             full;
  logic [SUM_W-1:0] sum_next;

  assign full     = fill == FILL_W'(WINDOW);
  assign sum_next = sum - (full ? SUM_W'(old_q) : '0) + SUM_W'(soc);

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[wptr] <= soc;
    end
    if (ctrl.rd) begin
      old_q <= mem[wptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      fill <= '0;
      sum  <= '0;
    end else if (ctrl.wr) begin
      sum  <= sum_next;
      fill <= full ? fill : fill + 1'b1;
      wptr <= (wptr == PTR_W'(WINDOW - 1)) ? '0 : wptr + 1'b1;
    end
  end

endmodule

FILE: design/battery_soc_estimator.sv
// ----------------------------------------------------------------------------
// Battery state-of-charge estimator
// Scales a converter sample to millivolts, interpolates state of charge
// from the open-circuit-voltage table and averages over a sample window.
//
//   Channel  Signals                                    Direction
//   in       in_valid, in_stall, adc_count, charging    request in
//   out      out_valid, out_stall, soc_tenths,          request out
//            avg_soc_tenths, charging_out, filled
//   cfg      psel, penable, pwrite, paddr, pwdata,      register access
//            prdata, pready
//
// A request is accepted only in the idle state, so no new request is taken
// until the previous result has been loaded into the output registers; the
// serial multiplier and the shared serial divider set how long a request takes.
// Reset clears the control state, the window count and sum, and the registers.
// A result waiting on out_stall holds its outputs while the next request
// is already accepted and computed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_soc_estimator #(
  parameter int WINDOW = 100
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bse_pkg::ADC_BITS-1:0]  adc_count,
  input  logic                          charging,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bse_pkg::SOC_W-1:0]     soc_tenths,
  output logic [bse_pkg::SOC_W-1:0]     avg_soc_tenths,
  output logic                          charging_out,
  output logic [bse_pkg::FILLED_W-1:0]  filled,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bse_pkg::PADDR_W-1:0]   paddr,
  input  logic [bse_pkg::PDATA_W-1:0]   pwdata,
  output logic [bse_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import bse_pkg::*;

  `include "battery_soc_estimator_defines.svh"

  localparam int SUM_W     = $clog2(WINDOW * 1000 + 1);
  localparam int FILL_W    = $clog2(WINDOW + 1);
  localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DIV_NUM_W = (INTERP_W > SUM_W) ? INTERP_W : SUM_W;
  localparam int DIV_DEN_W = (SEG_W > FILL_W) ? SEG_W : FILL_W;

  state_t state;
  state_t state_next;

  logic [GAIN_W-1:0]    gain_q16;
  logic [OFS_W-1:0]     charge_offset_mv;
  logic                 cfg_write;

  logic                 chg_r;
  logic [MV_W-1:0]      mv;
  logic [MV_W-1:0]      mv_raw;
  logic [MV_W-1:0]      mv_adj;
  logic [SEG_IDX_W-1:0] seg;
  logic [SEG_IDX_W-1:0] seg_cnt;
  logic [SEG_IDX_W-1:0] seg_hi;
  logic                 below;
  logic                 above;
  logic [SOC_W-1:0]     soc_r;
  logic [SOC_W-1:0]     soc_val;
  logic [SOC_W-1:0]     avg_r;
  logic                 flat;

  logic [SEG_W-1:0]     seg_diff;
  logic [SEG_W-1:0]     seg_den;
  logic [STEP_W-1:0]    seg_step;
  logic [INTERP_W-1:0]  interp_num;

  logic                 mul_start;
  logic                 mul_done;
  logic [PROD_W-1:0]    product;

  logic                 div_start;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quot;

  ring_ctrl_t           ring_ctrl;
  logic [SUM_W-1:0]     ring_sum;
  logic [FILL_W-1:0]    ring_fill;
  logic [FILL_W+FILLED_W-1:0] fill_ext;
  logic                 out_load;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q16         <= GAIN_RESET;
      charge_offset_mv <= OFS_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel_t'(paddr[2]))
        REG_GAIN:   gain_q16         <= pwdata[GAIN_W-1:0];
        REG_OFFSET: charge_offset_mv <= pwdata[OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel_t'(paddr[2]))
      REG_GAIN:   prdata = PDATA_W'(gain_q16);
      REG_OFFSET: prdata = PDATA_W'(charge_offset_mv);
      default:    prdata = '0;
    endcase
  end

  bse_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .adc     (adc_count),
    .gain    (gain_q16),
    .done    (mul_done),
    .product (product)
  );

  bse_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  bse_ring #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .FILL_W (FILL_W),
    .PTR_W  (PTR_W)
  ) u_ring (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ring_ctrl),
    .soc  (soc_r),
    .sum  (ring_sum),
    .fill (ring_fill)
  );

  // Voltage after the charging offset, clamped at zero.
  assign mv_raw = product[PROD_W-1:GAIN_FRAC];
  assign mv_adj = (chg_r && (mv_raw <= MV_W'(charge_offset_mv))) ? '0 :
                  (chg_r ? mv_raw - MV_W'(charge_offset_mv) : mv_raw);

  // The segment index is the number of upper breakpoints below the voltage.
  always_comb begin
    seg_cnt = '0;
    for (int j = 1; j < TABLE_POINTS; j++) begin
      seg_cnt = seg_cnt + SEG_IDX_W'(mv > OCV_MV[j]);
    end
  end
  assign seg_hi = SEG_IDX_W'(TABLE_POINTS - 2);

  assign seg_diff   = SEG_W'(mv - OCV_MV[seg]);
  assign seg_den    = SEG_W'(OCV_MV[seg + 1'b1] - OCV_MV[seg]);
  assign seg_step   = STEP_W'(SOC_PTS[seg + 1'b1] - SOC_PTS[seg]);
  assign interp_num = INTERP_W'(seg_diff) * INTERP_W'(seg_step);
  assign flat       = (OCV_MV[seg + 1'b1] <= OCV_MV[seg]) ||
                      (SOC_PTS[seg + 1'b1] < SOC_PTS[seg]);

  always_comb begin
    if (below) begin
      soc_val = SOC_PTS[0];
    end else if (above) begin
      soc_val = SOC_PTS[TABLE_POINTS-1];
    end else if (flat) begin
      soc_val = SOC_PTS[seg];
    end else begin
      soc_val = SOC_PTS[seg] + div_quot[SOC_W-1:0];
    end
  end

  always_comb begin
    if (state == ST_ASTART) begin
      div_num = DIV_NUM_W'(ring_sum);
      div_den = DIV_DEN_W'(ring_fill);
    end else begin
      div_num = DIV_NUM_W'(interp_num);
      div_den = DIV_DEN_W'(seg_den);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MUL;
      ST_MUL:    if (mul_done) state_next = ST_SEG;
      ST_SEG:    state_next = ST_ISTART;
      ST_ISTART: state_next = ST_IDIV;
      ST_IDIV:   if (div_done) state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_ASTART;
      ST_ASTART: state_next = ST_ADIV;
      ST_ADIV:   if (div_done) state_next = ST_OUT;
      ST_OUT:    if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = state != ST_IDLE;
    mul_start    = (state == ST_IDLE) && in_valid;
    ring_ctrl.rd = (state == ST_IDLE) && in_valid;
    ring_ctrl.wr = state == ST_COMMIT;
    div_start    = (state == ST_ISTART) || (state == ST_ASTART);
    out_load     = (state == ST_OUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      chg_r <= charging;
    end
    if ((state == ST_MUL) && mul_done) begin
      mv <= mv_adj;
    end
    if (state == ST_SEG) begin
      seg   <= (seg_cnt > seg_hi) ? seg_hi : seg_cnt;
      below <= mv <= OCV_MV[0];
      above <= mv >= OCV_MV[TABLE_POINTS-1];
    end
    if ((state == ST_IDIV) && div_done) begin
      soc_r <= soc_val;
    end
    if ((state == ST_ADIV) && div_done) begin
      avg_r <= div_quot[SOC_W-1:0];
    end
  end

  assign fill_ext = {{FILLED_W{1'b0}}, ring_fill};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      soc_tenths     <= soc_r;
      avg_soc_tenths <= avg_r;
      charging_out   <= chg_r;
      filled         <= fill_ext[FILLED_W-1:0];
    end
  end

  `BSE_ASSERT_IMPL(a_mul_done_in_mul, mul_done, state == ST_MUL, "multiplier done outside MUL")
  `BSE_ASSERT_IMPL(a_div_done, div_done, state == ST_IDIV || state == ST_ADIV, "stray div done")
  `BSE_ASSERT_NEXT(a_commit_fills, ring_ctrl.wr, ring_fill != '0, "window empty after commit")
  `BSE_ASSERT_NEXT(a_out_load, out_load, out_valid && state == ST_IDLE, "no result after load")

endmodule

FILE: dv/tb_battery_soc_estimator.sv
// ----------------------------------------------------------------------------
// Battery state-of-charge estimator testbench
// Drives converter samples through the request channel and programs the
// gain and charge offset over the register port. A local predictor scales
// each sample, looks it up in the voltage table and keeps its own averaging
// window. Every result is compared field by field with the oldest
// prediction, under random idling, long output holds and a quiet tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_battery_soc_estimator;
  import bse_pkg::*;

  localparam int     WIN_DEPTH     = 100;
  localparam int     SETTLE_CYCLES = 60;
  localparam longint TIMEOUT_NS    = 64'd20_000_000;

  typedef struct {
    logic [SOC_W-1:0]    soc;
    logic [SOC_W-1:0]    avg;
    logic                chg;
    logic [FILLED_W-1:0] filled;
  } soc_report_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [ADC_BITS-1:0] adc_count;
  logic                charging;
  logic                out_valid;
  logic                out_stall;
  logic [SOC_W-1:0]    soc_tenths;
  logic [SOC_W-1:0]    avg_soc_tenths;
  logic                charging_out;
  logic [FILLED_W-1:0] filled;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  soc_report_t         pending_reports[$];
  logic [GAIN_W-1:0]   gain_model = GAIN_RESET;
  logic [OFS_W-1:0]    offset_model = OFS_RESET;
  logic [SOC_W-1:0]    window_model[WIN_DEPTH];
  int                  win_ptr = 0;
  int                  win_fill = 0;
  int unsigned         win_sum = 0;
  int                  mismatches = 0;
  int                  hold_left = 0;
  int                  calm_requests = 0;
  bit                  quiet = 0;

  battery_soc_estimator #(
    .WINDOW(WIN_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .adc_count     (adc_count),
    .charging      (charging),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .soc_tenths    (soc_tenths),
    .avg_soc_tenths(avg_soc_tenths),
    .charging_out  (charging_out),
    .filled        (filled),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [SOC_W-1:0] soc_from_sample(logic [ADC_BITS-1:0] cnt, logic chg);
    logic [PROD_W-1:0] prod;
    int unsigned       mv;
    int unsigned       v0;
    int unsigned       v1;
    int unsigned       p0;
    int unsigned       p1;
    prod = cnt * gain_model;
    mv = 32'(prod >> GAIN_FRAC);
    if (chg) begin
      mv = (mv > offset_model) ? mv - 32'(offset_model) : 0;
    end
    if (mv <= OCV_MV[0]) return SOC_PTS[0];
    if (mv >= OCV_MV[TABLE_POINTS-1]) return SOC_PTS[TABLE_POINTS-1];
    for (int i = 1; i < TABLE_POINTS; i++) begin
      if (mv <= OCV_MV[i]) begin
        v0 = 32'(OCV_MV[i-1]);
        v1 = 32'(OCV_MV[i]);
        p0 = 32'(SOC_PTS[i-1]);
        p1 = 32'(SOC_PTS[i]);
        if (v1 <= v0 || p1 < p0) return SOC_W'(p0);
        return SOC_W'(p0 + ((mv - v0) * (p1 - p0)) / (v1 - v0));
      end
    end
    return SOC_PTS[TABLE_POINTS-1];
  endfunction

  task automatic advance_window(logic [ADC_BITS-1:0] cnt, logic chg);
    soc_report_t rep;
    rep.soc = soc_from_sample(cnt, chg);
    if (win_fill >= WIN_DEPTH) begin
      win_sum -= 32'(window_model[win_ptr]);
    end else begin
      win_fill++;
    end
    window_model[win_ptr] = rep.soc;
    win_sum += 32'(rep.soc);
    win_ptr = (win_ptr + 1) % WIN_DEPTH;
    rep.avg = SOC_W'(win_sum / win_fill);
    rep.chg = chg;
    rep.filled = FILLED_W'(win_fill);
    pending_reports.push_back(rep);
  endtask

  task automatic send_request(logic [ADC_BITS-1:0] cnt, logic chg);
    int gap;
    gap = 0;
    if (calm_requests > 0) begin
      calm_requests--;
    end else if ($urandom_range(0, 40) == 0) begin
      calm_requests = $urandom_range(10, 40);
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    adc_count <= cnt;
    charging  <= chg;
    do @(posedge clk); while (in_stall);
    advance_window(cnt, chg);
  endtask

  task automatic send_random_request();
    int unsigned target;
    int unsigned cnt;
    logic        chg;
    chg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: begin
        cnt = $urandom_range(0, 1) ? 4095 : 0;
      end
      1, 2, 3: begin
        cnt = $urandom_range(0, 4095);
      end
      default: begin
        target = $urandom_range(2950, 4250) + (chg ? offset_model : 0);
        cnt = (gain_model == 0) ? $urandom_range(0, 4095) : (target << GAIN_FRAC) / gain_model;
        if (cnt > 4095) cnt = 4095;
      end
    endcase
    send_request(cnt[ADC_BITS-1:0], chg);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_reports.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_sel_t sel, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_GAIN:   gain_model = value[GAIN_W-1:0];
      REG_OFFSET: offset_model = value[OFS_W-1:0];
      default:    ;
    endcase
  endtask

  task automatic program_estimator(int unsigned gain, int unsigned offset);
    drain_requests();
    write_reg(REG_GAIN, gain);
    write_reg(REG_OFFSET, offset);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %0d, actual %0d", name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    soc_report_t rep;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: soc_tenths %0d, avg_soc_tenths %0d, filled %0d",
                   soc_tenths, avg_soc_tenths, filled);
        end
      end else begin
        rep = pending_reports.pop_front();
        check_field("soc_tenths", 16'(rep.soc), 16'(soc_tenths));
        check_field("avg_soc_tenths", 16'(rep.avg), 16'(avg_soc_tenths));
        check_field("charging_out", 16'(rep.chg), 16'(charging_out));
        check_field("filled", 16'(rep.filled), 16'(filled));
      end
    end
  end

  initial begin
    int burst_left;
    int calm_left;
    burst_left = 0;
    calm_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (quiet || calm_left > 0) begin
        if (calm_left > 0) calm_left--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 50) == 0) calm_left = $urandom_range(20, 100);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_reset_defaults();
    repeat (6) send_random_request();
  endtask

  // With a gain of exactly two millivolts per count, each sample maps onto a
  // known voltage, so table points and both clamps can be hit exactly.
  task automatic test_table_points();
    program_estimator(131072, 100);
    send_request(0, 0);
    send_request(4095, 0);
    send_request(1500, 0);
    send_request(1501, 0);
    send_request(2100, 0);
    send_request(2099, 0);
    send_request(1640, 0);
    send_request(1700, 0);
    send_request(1800, 0);
    send_request(1855, 0);
    send_request(1950, 0);
    send_request(1990, 0);
    send_request(2010, 0);
    send_request(2075, 0);
    send_request(2150, 1);
    send_request(40, 1);
    send_request(50, 1);
    send_request(1600, 1);
    send_request(4095, 1);
    program_estimator(131072, 500);
    send_request(2000, 1);
    send_request(200, 1);
    send_request(2350, 1);
  endtask

  task automatic test_register_extremes();
    program_estimator(0, 0);
    repeat (10) send_random_request();
    program_estimator(262143, 500);
    repeat (10) send_random_request();
    program_estimator(262143, 0);
    repeat (10) send_random_request();
    program_estimator(0, 500);
    repeat (10) send_random_request();
  endtask

  task automatic test_window_wrap();
    program_estimator(GAIN_RESET, OFS_RESET);
    repeat (250) send_random_request();
  endtask

  task automatic test_backpressure();
    drain_requests();
    hold_left = 400;
    repeat (15) send_random_request();
    drain_requests();
    repeat (15) send_random_request();
  endtask

  task automatic test_random_settings();
    int unsigned gain;
    for (int phase = 0; phase < 9; phase++) begin
      case ($urandom_range(0, 3))
        0:       gain = $urandom_range(0, 262143);
        1:       gain = 131072;
        default: gain = $urandom_range(150000, 190000);
      endcase
      program_estimator(gain, $urandom_range(0, 500));
      if (phase == 8) quiet = 1;
      repeat (phase == 8 ? 150 : 110) send_random_request();
    end
    drain_requests();
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    adc_count <= '0;
    charging  <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_table_points();
    test_register_extremes();
    test_window_wrap();
    test_backpressure();
    test_random_settings();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/bse_pkg.sv
design/bse_mul.sv
design/bse_div.sv
design/bse_ring.sv
design/battery_soc_estimator.sv
dv/tb_battery_soc_estimator.sv
